@@ hw/rtl/tkds_pkg.sv @@
package tkds_pkg;

  localparam int unsigned SCORE_FIELD_W = 24;
  localparam int unsigned COUNT_FIELD_W = 3;
  localparam int unsigned SHOWN_SLOTS   = 5;
  localparam int unsigned COUNT_WIDE_W  = 6;
  localparam int unsigned SCORE_WIDE_W  = 32;
  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned OUT_TDATA_W   = 128;
  localparam int unsigned OUT_USED_W    = COUNT_FIELD_W + SHOWN_SLOTS * SCORE_FIELD_W;

  typedef struct packed {
    logic gt;
    logic eq;
  } tkds_flags_t;

endpackage

@@ hw/rtl/tkds_cell.sv @@
module tkds_cell #(
  parameter int unsigned SCORE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [SCORE_BITS-1:0]  score,
  input  logic                   valid,
  input  logic                   dup,
  input  logic [SCORE_BITS-1:0]  prev_value,
  input  logic                   prev_gt,
  output logic [SCORE_BITS-1:0]  value_o,
  output logic [SCORE_BITS-1:0]  value_nxt_o,
  output tkds_pkg::tkds_flags_t  flags_o
);

  logic [SCORE_BITS-1:0] value_r;
  logic [SCORE_BITS-1:0] value_nxt;

  always_comb begin
    flags_o.gt = valid && (value_r > score);
    flags_o.eq = valid && (value_r == score);
    if (dup || flags_o.gt) begin
      value_nxt = value_r;
    end else if (prev_gt) begin
      value_nxt = score;
    end else begin
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value_nxt;
    end
  end

  assign value_o     = value_r;
  assign value_nxt_o = value_nxt;

endmodule

@@ hw/rtl/top_k_distinct_scores.sv @@
// Channel | Direction | tdata (low bit up)                          | tuser | tlast
// in_     | request   | score[23:0]                                 | -     | last_of_history
// out_    | result    | kept_count[2:0], rank_one .. rank_five 24b  | -     | -
//
// One request per cycle unless the output stalls: every cell compares the
// score against its entry in parallel and the row shifts by one place below
// the insertion point. The result sits in an output register; a new request
// is taken while it is being read. Synchronous active-low reset clears the
// entry count and the output valid; the entries themselves are not reset.
module top_k_distinct_scores #(
  parameter int unsigned KEEP_COUNT = 5,
  parameter int unsigned SCORE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tkds_pkg::IN_TDATA_W-1:0]    in_tdata,  // score
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tkds_pkg::OUT_TDATA_W-1:0]   out_tdata  // kept_count, rank_one..rank_five
);

  localparam int unsigned CNT_W = $clog2(KEEP_COUNT + 1);

  logic                        load;
  logic [tkds_pkg::SCORE_WIDE_W-1:0] score_wide;
  logic [SCORE_BITS-1:0]       score;
  logic [KEEP_COUNT-1:0]       valid;
  logic [KEEP_COUNT-1:0]       gt;
  logic [KEEP_COUNT-1:0]       eq;
  logic [SCORE_BITS-1:0]       value [KEEP_COUNT];
  logic [SCORE_BITS-1:0]       value_nxt [KEEP_COUNT];
  tkds_pkg::tkds_flags_t       flags [KEEP_COUNT];
  logic                        dup;
  logic                        insert;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [tkds_pkg::COUNT_WIDE_W-1:0] count_wide;
  logic [tkds_pkg::COUNT_FIELD_W-1:0] kept;
  logic [tkds_pkg::SCORE_FIELD_W-1:0] rank [tkds_pkg::SHOWN_SLOTS];
  logic [tkds_pkg::OUT_TDATA_W-1:0]   out_data_nxt;
  logic [tkds_pkg::OUT_TDATA_W-1:0]   out_data_r;
  logic                        out_valid_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign load       = in_tvalid && in_tready;
  assign score_wide = tkds_pkg::SCORE_WIDE_W'(in_tdata[tkds_pkg::SCORE_FIELD_W-1:0]);
  assign score      = score_wide[SCORE_BITS-1:0];

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    assign valid[i] = count_r > CNT_W'(i);
    assign gt[i]    = flags[i].gt;
    assign eq[i]    = flags[i].eq;
    if (i == 0) begin : g_head
      tkds_cell #(.SCORE_BITS(SCORE_BITS)) u_cell (
        .clk         (clk),
        .load        (load),
        .score       (score),
        .valid       (valid[i]),
        .dup         (dup),
        .prev_value  (score),
        .prev_gt     (1'b1),
        .value_o     (value[i]),
        .value_nxt_o (value_nxt[i]),
        .flags_o     (flags[i])
      );
    end else begin : g_body
      tkds_cell #(.SCORE_BITS(SCORE_BITS)) u_cell (
        .clk         (clk),
        .load        (load),
        .score       (score),
        .valid       (valid[i]),
        .dup         (dup),
        .prev_value  (value[i-1]),
        .prev_gt     (gt[i-1]),
        .value_o     (value[i]),
        .value_nxt_o (value_nxt[i]),
        .flags_o     (flags[i])
      );
    end
  end

  assign dup    = |eq;
  assign insert = !dup && !gt[KEEP_COUNT-1];

  always_comb begin
    count_nxt = count_r;
    if (insert && (count_r < CNT_W'(KEEP_COUNT))) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign count_wide = tkds_pkg::COUNT_WIDE_W'(count_nxt);
  assign kept = (count_wide > tkds_pkg::COUNT_WIDE_W'(7)) ? 3'd7 :
                count_wide[tkds_pkg::COUNT_FIELD_W-1:0];

  for (genvar k = 0; k < tkds_pkg::SHOWN_SLOTS; k++) begin : g_slot
    if (k < KEEP_COUNT) begin : g_kept
      logic [tkds_pkg::SCORE_WIDE_W-1:0] slot_wide;
      assign slot_wide = tkds_pkg::SCORE_WIDE_W'(value_nxt[k]);
      assign rank[k] = (count_nxt > CNT_W'(k)) ?
                       slot_wide[tkds_pkg::SCORE_FIELD_W-1:0] : '0;
    end else begin : g_none
      assign rank[k] = '0;
    end
  end

  assign out_data_nxt = tkds_pkg::OUT_TDATA_W'({rank[4], rank[3], rank[2], rank[1], rank[0],
                                                 kept});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        count_r     <= in_tlast ? '0 : count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
